// ===== src/ibfp_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// ibfp_pkg
// Types and constants shared by the inertial burst frame parser.
// ---------------------------------------------------------------------------
package ibfp_pkg;

	localparam int unsigned POS_W = 5;
	localparam int unsigned WORD_W = 16;
	localparam int unsigned WORD_COUNT = 8;
	localparam int unsigned SLOT_W = 3;

	localparam logic [POS_W-1:0] FRAME_LEN = 5'd24;
	localparam logic [POS_W-1:0] SUM_FIRST = 5'd3;
	localparam logic [POS_W-1:0] SUM_LAST = 5'd20;
	localparam logic [POS_W-1:0] WORD_FIRST = 5'd5;
	localparam logic [POS_W-1:0] WORD_LAST = 5'd20;
	localparam logic [POS_W-1:0] CHECK_POS = 5'd22;
	localparam logic [POS_W-1:0] EMIT_POS = 5'd23;
	localparam logic [SLOT_W-1:0] COUNTER_SLOT = 3'd7;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_start;
	} in_word_t;

	typedef struct packed {
		logic signed [15:0] gyro_x;
		logic signed [15:0] gyro_y;
		logic signed [15:0] gyro_z;
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
		logic signed [15:0] temperature;
		logic [15:0]        tick_delta;
		logic               checksum_ok;
	} out_word_t;

endpackage
`default_nettype wire

// ===== src/ibfp_capture.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// ibfp_capture
// Byte position tracking, running sum, word capture and result assembly.
// ---------------------------------------------------------------------------
module ibfp_capture (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              fire,
	input  wire ibfp_pkg::in_word_t in_data,
	output logic                   at_emit,
	output logic                   emit,
	output ibfp_pkg::out_word_t    result
);

	logic [ibfp_pkg::POS_W-1:0]  pos_q;
	logic [7:0]                  sum_q;
	logic [7:0]                  hold_q;
	logic [ibfp_pkg::WORD_W-1:0] words_q [ibfp_pkg::WORD_COUNT];
	logic [ibfp_pkg::WORD_W-1:0] prev_q;

	logic [ibfp_pkg::POS_W-1:0]  pos;
	logic [ibfp_pkg::POS_W-1:0]  rel;
	logic [ibfp_pkg::SLOT_W-1:0] slot;
	logic                        active;
	logic                        in_sum;
	logic                        in_words;
	logic                        is_check;

	// a start overrides the stored position for this very byte
	assign pos      = in_data.frame_start ? '0 : pos_q;
	assign active   = pos < ibfp_pkg::FRAME_LEN;
	assign rel      = pos - ibfp_pkg::WORD_FIRST;
	assign slot     = rel[ibfp_pkg::SLOT_W:1];
	assign in_sum   = (pos >= ibfp_pkg::SUM_FIRST) && (pos <= ibfp_pkg::SUM_LAST);
	assign in_words = (pos >= ibfp_pkg::WORD_FIRST) && (pos <= ibfp_pkg::WORD_LAST);
	assign is_check = pos == ibfp_pkg::CHECK_POS;

	assign at_emit = pos_q == ibfp_pkg::EMIT_POS;
	assign emit    = fire && (pos == ibfp_pkg::EMIT_POS);

	always_comb begin
		result.gyro_x      = $signed(words_q[0]);
		result.gyro_y      = $signed(words_q[1]);
		result.gyro_z      = $signed(words_q[2]);
		result.accel_x     = $signed(words_q[3]);
		result.accel_y     = $signed(words_q[4]);
		result.accel_z     = $signed(words_q[5]);
		result.temperature = $signed(words_q[6]);
		result.tick_delta  = words_q[ibfp_pkg::COUNTER_SLOT] - prev_q;
		result.checksum_ok = sum_q == hold_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= ibfp_pkg::FRAME_LEN;
			sum_q  <= '0;
			hold_q <= '0;
			prev_q <= '0;
			for (int i = 0; i < int'(ibfp_pkg::WORD_COUNT); i++) begin
				words_q[i] <= '0;
			end
		end else if (fire) begin
			// a start always lands in the active branch below, which moves pos_q to 1
			if (in_data.frame_start) begin
				sum_q <= '0;
			end
			if (active) begin
				pos_q <= pos + 1'b1;
				if (in_sum) begin
					sum_q <= (in_data.frame_start ? 8'd0 : sum_q) + in_data.rx_byte;
				end
				if (in_words) begin
					if (!rel[0]) begin
						hold_q <= in_data.rx_byte;
					end else begin
						words_q[slot] <= {hold_q, in_data.rx_byte};
					end
				end else if (is_check) begin
					hold_q <= in_data.rx_byte;
				end else if (emit) begin
					prev_q <= words_q[ibfp_pkg::COUNTER_SLOT];
				end
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/imu_burst_frame_parser.sv =====
// Output: the result shows on out_* in the cycle after the accept of byte 23.
// Throughput: one byte per cycle; in_ready drops only while the parser waits for
// byte 23 and the single output register still holds an untaken result.
// Reset: arst_n clears position to idle (waits for a start), sum, words and counter.
`default_nettype none
// ---------------------------------------------------------------------------
// imu_burst_frame_parser
// Parses a 24-byte inertial burst reply byte by byte into one sample word.
// ---------------------------------------------------------------------------
module imu_burst_frame_parser (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire ibfp_pkg::in_word_t in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output ibfp_pkg::out_word_t     out_data
);

	logic                in_fire;
	logic                at_emit;
	logic                emit;
	ibfp_pkg::out_word_t result;
	logic                out_valid_q;
	ibfp_pkg::out_word_t out_data_q;

	// stall only the emitting byte, and only if the result slot stays full
	assign in_ready = !(at_emit && out_valid_q && !out_ready);
	assign in_fire  = in_valid && in_ready;

	ibfp_capture u_capture (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (in_fire),
		.in_data (in_data),
		.at_emit (at_emit),
		.emit    (emit),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
`default_nettype wire

// ===== sim/ibfp_frame_checker.sv =====
// ---------------------------------------------------------------------------
// ibfp_frame_checker
// Watches both channels of the burst frame parser, rebuilds each sample from
// the accepted bytes and compares every returned word field by field.
// ---------------------------------------------------------------------------
module ibfp_frame_checker (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic                in_ready,
	input  wire ibfp_pkg::in_word_t  in_data,
	input  wire logic                out_valid,
	input  wire logic                out_ready,
	input  wire ibfp_pkg::out_word_t out_data,
	output int                       fail_count,
	output int                       pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// shadow of the parser state
	logic [ibfp_pkg::POS_W-1:0]  frame_pos = ibfp_pkg::FRAME_LEN;
	logic [7:0]                  byte_sum = '0;
	logic [7:0]                  held_byte = '0;
	logic [ibfp_pkg::WORD_W-1:0] sensor_words [ibfp_pkg::WORD_COUNT] = '{default: '0};
	logic [ibfp_pkg::WORD_W-1:0] last_tick = '0;

	ibfp_pkg::out_word_t sample_q [$];

	task automatic note_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		fail_count++;
	endtask

	task automatic compare_field(input string name, input logic [15:0] got,
		input logic [15:0] want);
		if (got !== want)
			note_mismatch($sformatf("%s got %04h expected %04h", name, got, want));
	endtask

	task automatic parse_byte(input ibfp_pkg::in_word_t w);
		logic [ibfp_pkg::POS_W-1:0] p;
		logic [3:0]                 rel;
		ibfp_pkg::out_word_t        s;
		if (w.frame_start) begin
			frame_pos = '0;
			byte_sum = '0;
		end
		p = frame_pos;
		if (p >= ibfp_pkg::FRAME_LEN)
			return;
		if (p >= ibfp_pkg::SUM_FIRST && p <= ibfp_pkg::SUM_LAST)
			byte_sum += w.rx_byte;
		if (p >= ibfp_pkg::WORD_FIRST && p <= ibfp_pkg::WORD_LAST) begin
			rel = 4'(p - ibfp_pkg::WORD_FIRST);
			if (!rel[0])
				held_byte = w.rx_byte;
			else
				sensor_words[rel[3:1]] = {held_byte, w.rx_byte};
		end else if (p == ibfp_pkg::CHECK_POS) begin
			held_byte = w.rx_byte;
		end else if (p == ibfp_pkg::EMIT_POS) begin
			s.gyro_x = sensor_words[0];
			s.gyro_y = sensor_words[1];
			s.gyro_z = sensor_words[2];
			s.accel_x = sensor_words[3];
			s.accel_y = sensor_words[4];
			s.accel_z = sensor_words[5];
			s.temperature = sensor_words[6];
			s.tick_delta = sensor_words[ibfp_pkg::COUNTER_SLOT] - last_tick;
			s.checksum_ok = (byte_sum == held_byte);
			sample_q.push_back(s);
			last_tick = sensor_words[ibfp_pkg::COUNTER_SLOT];
		end
		frame_pos = p + 1'b1;
	endtask

	task automatic check_sample(input ibfp_pkg::out_word_t got);
		ibfp_pkg::out_word_t want;
		if (sample_q.size() == 0) begin
			note_mismatch("word out with no frame pending");
			return;
		end
		want = sample_q.pop_front();
		compare_field("gyro_x", got.gyro_x, want.gyro_x);
		compare_field("gyro_y", got.gyro_y, want.gyro_y);
		compare_field("gyro_z", got.gyro_z, want.gyro_z);
		compare_field("accel_x", got.accel_x, want.accel_x);
		compare_field("accel_y", got.accel_y, want.accel_y);
		compare_field("accel_z", got.accel_z, want.accel_z);
		compare_field("temperature", got.temperature, want.temperature);
		compare_field("tick_delta", got.tick_delta, want.tick_delta);
		compare_field("checksum_ok", {15'd0, got.checksum_ok}, {15'd0, want.checksum_ok});
	endtask

	// input first: a word leaving on the same edge always belongs to an older frame
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				parse_byte(in_data);
			if (out_valid && out_ready)
				check_sample(out_data);
			pending = sample_q.size();
		end
	end

endmodule

// ===== sim/tb_imu_burst_frame_parser.sv =====
// ---------------------------------------------------------------------------
// tb_imu_burst_frame_parser
// Drives burst replies byte by byte into the parser: a directed frame with
// extreme words, then random frames with bad sums, restarts and stray bytes,
// under three idle profiles and one long output stall.
// ---------------------------------------------------------------------------
module tb_imu_burst_frame_parser;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_HOLD = 400;
	localparam int BYTES_PER_PHASE = 300;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	ibfp_pkg::in_word_t  in_data = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	ibfp_pkg::out_word_t out_data;

	int fail_count;
	int pending;

	int        send_idle_pct = 22;
	int        recv_idle_pct = 53;
	bit        hold_req = 1'b0;
	bit        hold_served = 1'b0;
	int        hold_left = 0;
	int        cycle_count = 0;
	int        frame_bytes = 0;
	logic [15:0] tx_tick = '0;

	imu_burst_frame_parser dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	ibfp_frame_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.fail_count(fail_count),
		.pending   (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// output side: random stalls plus one long hold-off on request
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (hold_req && !hold_served) begin
			hold_served <= 1'b1;
			hold_left <= LONG_HOLD;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic put_byte(input logic [7:0] b, input logic st);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{rx_byte: b, frame_start: st};
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// cut < 24 drops the frame partway; the next start restarts the parser
	task automatic send_frame(input int cut, input bit directed);
		logic [7:0]  fb [24];
		logic [15:0] w;
		logic [7:0]  sum;
		logic [15:0] edge_words [7];
		edge_words = '{16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000, 16'h0001, 16'hFF80, 16'h8001};
		for (int i = 0; i < 24; i++)
			fb[i] = directed ? 8'hFF : 8'($urandom_range(255));
		for (int k = 0; k < 7; k++) begin
			if (directed)
				w = edge_words[k];
			else if ($urandom_range(3) == 0)
				w = edge_words[$urandom_range(3)];
			else
				w = 16'($urandom_range(65535));
			fb[5 + 2 * k] = w[15:8];
			fb[6 + 2 * k] = w[7:0];
		end
		if (directed)
			tx_tick = 16'hFFFF;
		else if ($urandom_range(1) == 0)
			tx_tick += 16'($urandom_range(1, 4));
		else
			tx_tick = 16'($urandom_range(65535));
		fb[19] = tx_tick[15:8];
		fb[20] = tx_tick[7:0];
		sum = '0;
		for (int i = 3; i <= 20; i++)
			sum += fb[i];
		if (!directed && $urandom_range(99) < 20)
			fb[22] = sum ^ 8'($urandom_range(1, 255));
		else
			fb[22] = sum;
		for (int i = 0; i < cut; i++)
			put_byte(fb[i], i == 0);
		frame_bytes += cut;
	endtask

	initial begin
		int target;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// stray byte while idle, extreme frame, byte past the end
		put_byte(8'hA5, 1'b0);
		send_frame(24, 1'b1);
		put_byte(8'h3C, 1'b0);
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 22;
					recv_idle_pct = 53;
					hold_req = 1'b1;
				end
				1: begin
					send_idle_pct = 53;
					recv_idle_pct = 22;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			target = frame_bytes + BYTES_PER_PHASE;
			while (frame_bytes < target) begin
				if ($urandom_range(9) == 0)
					drain();
				send_frame(($urandom_range(9) == 0) ? $urandom_range(1, 23) : 24, 1'b0);
				if ($urandom_range(9) == 0)
					repeat ($urandom_range(1, 3))
						put_byte(8'($urandom_range(255)), 1'b0);
			end
			drain();
		end

		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
